// ----- hw/rtl/ookpwm_pkg.sv -----
// Shared types and constants for the OOK PWM sensor frame encoder.
// No dependencies; imported by the interfaces and all modules.
package ookpwm_pkg;

   localparam int FRAME_MAX_BITS = 40;
   localparam int TIME_W         = 16;
   localparam int KIND_W         = 3;
   localparam int CSR_IDX_W      = 3;

   localparam logic [KIND_W-1:0] KIND_SYNC     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SYNC_GAP = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ZERO     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ONE      = 3'd3;
   localparam logic [KIND_W-1:0] KIND_MSG_GAP  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_HIGH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_LOW    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_GAP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_LOW    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_LOW     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MSG_GAP_LOW = 3'd5;

   localparam logic [TIME_W-1:0] RST_PULSE_HIGH  = 16'd512;
   localparam logic [TIME_W-1:0] RST_SYNC_LOW    = 16'd480;
   localparam logic [TIME_W-1:0] RST_SYNC_GAP    = 16'd8912;
   localparam logic [TIME_W-1:0] RST_ZERO_LOW    = 16'd976;
   localparam logic [TIME_W-1:0] RST_ONE_LOW     = 16'd1968;
   localparam logic [TIME_W-1:0] RST_MSG_GAP_LOW = 16'd10200;

   typedef struct packed {
      logic [TIME_W-1:0] pulse_high;
      logic [TIME_W-1:0] sync_low;
      logic [TIME_W-1:0] sync_gap_low;
      logic [TIME_W-1:0] zero_low;
      logic [TIME_W-1:0] one_low;
      logic [TIME_W-1:0] msg_gap_low;
   } cfg_type;

endpackage

// ----- hw/rtl/ookpwm_if.sv -----
// Valid/ready channel interfaces: sensor reading in, pulse command out.
// Depends on ookpwm_pkg.
interface ookpwm_req_if
   import ookpwm_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [7:0]        sensor_id;
   logic [3:0]        status_bits;
   logic signed [11:0] temperature;
   logic [7:0]        humidity;

   modport source (output valid, output sensor_id, output status_bits,
                   output temperature, output humidity, input ready);
   modport sink   (input valid, input sensor_id, input status_bits,
                   input temperature, input humidity, output ready);
endinterface

interface ookpwm_rsp_if
   import ookpwm_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] pulse_kind;
   logic [TIME_W-1:0] high_time;
   logic [TIME_W-1:0] low_time;
   logic              last;

   modport source (output valid, output pulse_kind, output high_time,
                   output low_time, output last, input ready);
   modport sink   (input valid, input pulse_kind, input high_time,
                   input low_time, input last, output ready);
endinterface

// ----- hw/rtl/ookpwm_front.sv -----
// Front end: accepts a reading, packs the frame with checksum, registers it.
// Depends on ookpwm_pkg and ookpwm_req_if.
module ookpwm_front
   import ookpwm_pkg::*;
#(
   parameter int FRAME_BITS = 40
) (
   input  logic                  clock,
   input  logic                  reset,
   ookpwm_req_if.sink            req,
   output logic                  frm_valid,
   input  logic                  frm_ready,
   output logic [FRAME_BITS-1:0] frm_data
);

   logic [7:0]                b0, b1, b2, b3, csum;
   logic [FRAME_MAX_BITS-1:0] frame;
   logic                      valid_ff, valid_in;
   logic [FRAME_BITS-1:0]     data_ff, data_in;
   logic                      accept;

   assign b0    = req.sensor_id;
   assign b1    = {req.status_bits, req.temperature[11:8]};
   assign b2    = req.temperature[7:0];
   assign b3    = req.humidity;
   assign csum  = b0 + b1 + b2 + b3;
   assign frame = {b0, b1, b2, b3, csum};

   assign req.ready = !valid_ff || frm_ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (accept) begin
         valid_in = 1'b1;
         data_in  = frame[FRAME_MAX_BITS-1 -: FRAME_BITS];
      end else if (frm_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign frm_valid = valid_ff;
   assign frm_data  = data_ff;

endmodule

// ----- hw/rtl/ookpwm_queue.sv -----
// Two-entry frame queue between front and back ends.
// Depends on ookpwm_pkg.
module ookpwm_queue
   import ookpwm_pkg::*;
#(
   parameter int WIDTH = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ----- hw/rtl/ookpwm_back.sv -----
// Back end: steps through one frame, one pulse command word per cycle unless
// rsp stalls, into a registered output stage. Depends on ookpwm_pkg, ookpwm_rsp_if.
module ookpwm_back
   import ookpwm_pkg::*;
#(
   parameter int FRAME_BITS = 40
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  frm_valid,
   output logic                  frm_ready,
   input  logic [FRAME_BITS-1:0] frm_data,
   ookpwm_rsp_if.source          rsp
);

   localparam int CNT_W = $clog2(FRAME_BITS + 4);
   localparam logic [CNT_W-1:0] CNT_GAP  = CNT_W'(2);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BITS + 3);

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [FRAME_BITS-1:0] shift_ff, shift_in;
   logic                  out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [TIME_W-1:0]     low_ff, low_in;
   logic                  last_ff, last_in;
   logic                  emit, pop, is_last, is_bit;

   assign emit    = busy_ff && (!out_valid_ff || rsp.ready);
   assign is_last = (cnt_ff == CNT_LAST);
   assign is_bit  = (cnt_ff > CNT_GAP) && !is_last;
   assign pop     = frm_valid && (!busy_ff || (emit && is_last));
   assign frm_ready = !busy_ff || (emit && is_last);

   always_comb begin
      kind_in = KIND_SYNC;
      low_in  = cfg.sync_low;
      last_in = 1'b0;
      if (cnt_ff == CNT_GAP) begin
         kind_in = KIND_SYNC_GAP;
         low_in  = cfg.sync_gap_low;
      end else if (is_last) begin
         kind_in = KIND_MSG_GAP;
         low_in  = cfg.msg_gap_low;
         last_in = 1'b1;
      end else if (is_bit) begin
         if (shift_ff[FRAME_BITS-1]) begin
            kind_in = KIND_ONE;
            low_in  = cfg.one_low;
         end else begin
            kind_in = KIND_ZERO;
            low_in  = cfg.zero_low;
         end
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      if (pop) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = frm_data;
      end else if (emit) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
         if (is_bit) begin
            shift_in = shift_ff << 1;
         end
      end
      out_valid_in = emit ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
      shift_ff <= shift_in;
      if (emit) begin
         kind_ff <= kind_in;
         low_ff  <= low_in;
         last_ff <= last_in;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.pulse_kind = kind_ff;
   assign rsp.high_time  = cfg.pulse_high;
   assign rsp.low_time   = low_ff;
   assign rsp.last       = last_ff;

endmodule

// ----- hw/rtl/ook_pwm_sensor_frame_encoder_top.sv -----
// Top level of the OOK PWM sensor frame encoder: timing registers,
// front end, frame queue and back end. Depends on ookpwm_pkg, ookpwm_if,
// ookpwm_front, ookpwm_queue and ookpwm_back.
//
// Usage:
//   req_chan takes one sensor reading per word (id, status, temperature,
//   humidity). rsp_chan returns FRAME_BITS + 4 pulse command words per
//   reading: two sync, one sync gap, one zero/one word per frame bit sent
//   MSB first, and a message gap flagged last. high_time is the pulse
//   high register; low_time is the register of the word's kind.
//   csr_we/csr_index/csr_wdata write the six timing registers; indexes
//   past five are ignored. Write only while no reading is in flight.
//   An accepted reading passes the front register and the frame queue;
//   the back-end sequencer then sends one command word per cycle while
//   rsp_chan is ready, into a registered output. Readings queue in the
//   front register and a two-entry frame queue, so req_chan stays ready
//   while the back end works, until that space fills.
//   Reset clears all valid state and reloads the timing defaults.
//   When rsp_chan stalls the current word holds and the sequencer waits;
//   req_chan drops ready once the queue and the front register fill.
module ook_pwm_sensor_frame_encoder_top
   import ookpwm_pkg::*;
#(
   parameter int FRAME_BITS = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   ookpwm_req_if.sink           req_chan,
   ookpwm_rsp_if.source         rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]    csr_wdata
);

   cfg_type               cfg_ff, cfg_in;
   logic                  frm_valid, frm_ready;
   logic [FRAME_BITS-1:0] frm_data;
   logic                  bq_valid, bq_ready;
   logic [FRAME_BITS-1:0] bq_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PULSE_HIGH:  cfg_in.pulse_high   = csr_wdata;
            CSR_SYNC_LOW:    cfg_in.sync_low     = csr_wdata;
            CSR_SYNC_GAP:    cfg_in.sync_gap_low = csr_wdata;
            CSR_ZERO_LOW:    cfg_in.zero_low     = csr_wdata;
            CSR_ONE_LOW:     cfg_in.one_low      = csr_wdata;
            CSR_MSG_GAP_LOW: cfg_in.msg_gap_low  = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_high   <= RST_PULSE_HIGH;
         cfg_ff.sync_low     <= RST_SYNC_LOW;
         cfg_ff.sync_gap_low <= RST_SYNC_GAP;
         cfg_ff.zero_low     <= RST_ZERO_LOW;
         cfg_ff.one_low      <= RST_ONE_LOW;
         cfg_ff.msg_gap_low  <= RST_MSG_GAP_LOW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ookpwm_front #(
      .FRAME_BITS (FRAME_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .frm_valid (frm_valid),
      .frm_ready (frm_ready),
      .frm_data  (frm_data)
   );

   ookpwm_queue #(
      .WIDTH (FRAME_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (frm_valid),
      .in_ready  (frm_ready),
      .in_data   (frm_data),
      .out_valid (bq_valid),
      .out_ready (bq_ready),
      .out_data  (bq_data)
   );

   ookpwm_back #(
      .FRAME_BITS (FRAME_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .frm_valid (bq_valid),
      .frm_ready (bq_ready),
      .frm_data  (bq_data),
      .rsp       (rsp_chan)
   );

endmodule
